>>> sv/btkh_pkg.sv
package btkh_pkg;

  localparam int MAX_K    = 32;
  localparam int TAG_BITS = 32;
  localparam int DIST_W   = 32;
  localparam int IDX_W    = $clog2(MAX_K);
  localparam int CNT_W    = $clog2(MAX_K + 1);

  // register index, taken from paddr[2]
  localparam logic REG_K_LIMIT = 1'b0;

  typedef enum logic [1:0] {
    ACT_INSERT  = 2'd0,
    ACT_REPLACE = 2'd1,
    ACT_REJECT  = 2'd2,
    ACT_READOUT = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD,
    OP_UP,
    OP_DOWN,
    OP_SHIFT
  } cell_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP,
    ST_DOWN,
    ST_STATUS,
    ST_READ
  } state_t;

  typedef struct packed {
    cell_op_t              op;
    logic [IDX_W-1:0]      pos;
    logic [CNT_W-1:0]      fill;
    logic [DIST_W-1:0]     load_dist;
    logic [TAG_BITS-1:0]   load_tag;
  } cell_ctrl_t;

  typedef struct packed {
    logic up_swap;
    logic dn_swap_l;
    logic dn_swap_r;
  } cell_flags_t;

endpackage

>>> sv/btkh_cell.sv
module btkh_cell (
  input  logic                          clk,
  input  logic [btkh_pkg::IDX_W-1:0]    idx,
  input  btkh_pkg::cell_ctrl_t          ctrl,
  input  logic [btkh_pkg::DIST_W-1:0]   par_dist,
  input  logic [btkh_pkg::TAG_BITS-1:0] par_tag,
  input  btkh_pkg::cell_flags_t         par_flags,
  input  logic [btkh_pkg::DIST_W-1:0]   left_dist,
  input  logic [btkh_pkg::TAG_BITS-1:0] left_tag,
  input  btkh_pkg::cell_flags_t         left_flags,
  input  logic [btkh_pkg::DIST_W-1:0]   right_dist,
  input  logic [btkh_pkg::TAG_BITS-1:0] right_tag,
  input  btkh_pkg::cell_flags_t         right_flags,
  input  logic [btkh_pkg::DIST_W-1:0]   next_dist,
  input  logic [btkh_pkg::TAG_BITS-1:0] next_tag,
  output logic [btkh_pkg::DIST_W-1:0]   entry_dist,
  output logic [btkh_pkg::TAG_BITS-1:0] tag,
  output btkh_pkg::cell_flags_t         flags
);
  import btkh_pkg::*;

  logic [DIST_W-1:0]   entry_dist_next;
  logic [TAG_BITS-1:0] tag_next;
  logic [IDX_W+1:0]    lidx;
  logic [IDX_W+1:0]    ridx;
  logic [IDX_W+1:0]    fill_x;
  logic                active;
  logic                is_root;
  logic                is_left;
  logic                l_ok;
  logic                r_ok;
  logic                sel_r;
  logic                dn;
  logic [DIST_W-1:0]   sel_dist;
  logic [TAG_BITS-1:0] sel_tag;

  assign lidx    = (IDX_W+2)'({idx, 1'b1});
  assign ridx    = (IDX_W+2)'({idx, 1'b0}) + (IDX_W+2)'(2);
  assign fill_x  = (IDX_W+2)'(ctrl.fill);
  assign active  = (ctrl.pos == idx);
  assign is_root = (idx == '0);
  assign is_left = idx[0];

  assign l_ok     = (lidx < fill_x);
  assign r_ok     = (ridx < fill_x);
  // equal children: left wins
  assign sel_r    = r_ok && (left_dist < right_dist);
  assign sel_dist = sel_r ? right_dist : left_dist;
  assign sel_tag  = sel_r ? right_tag : left_tag;
  assign dn       = (ctrl.op == OP_DOWN) && active && l_ok && (entry_dist < sel_dist);

  assign flags.up_swap   = (ctrl.op == OP_UP) && active && !is_root &&
                           (par_dist < entry_dist);
  assign flags.dn_swap_l = dn && !sel_r;
  assign flags.dn_swap_r = dn && sel_r;

  always_comb begin
    entry_dist_next = entry_dist;
    tag_next        = tag;
    case (ctrl.op)
      OP_LOAD: begin
        if (active) begin
          entry_dist_next = ctrl.load_dist;
          tag_next        = ctrl.load_tag;
        end
      end
      OP_UP: begin
        if (flags.up_swap) begin
          entry_dist_next = par_dist;
          tag_next        = par_tag;
        end else if (left_flags.up_swap) begin
          entry_dist_next = left_dist;
          tag_next        = left_tag;
        end else if (right_flags.up_swap) begin
          entry_dist_next = right_dist;
          tag_next        = right_tag;
        end
      end
      OP_DOWN: begin
        if (dn) begin
          entry_dist_next = sel_dist;
          tag_next        = sel_tag;
        end else if (!is_root && ((is_left && par_flags.dn_swap_l) ||
                                  (!is_left && par_flags.dn_swap_r))) begin
          entry_dist_next = par_dist;
          tag_next        = par_tag;
        end
      end
      OP_SHIFT: begin
        entry_dist_next = next_dist;
        tag_next        = next_tag;
      end
      default: begin
        entry_dist_next = entry_dist;
        tag_next        = tag;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_dist <= entry_dist_next;
    tag        <= tag_next;
  end

endmodule

>>> sv/bounded_top_k_max_heap.sv
// Bounded top-k selector: keeps the k_limit candidates of smallest distance in a
// binary max-heap held by a row of cells, one heap entry per cell.
// Input channel (in_valid/in_ready): distance, tag, last_candidate. Output
// channel (out_valid/out_ready): one status item per candidate, and after a
// candidate marked last, one readout item per kept entry, root first.
// An item is taken only in the idle state; a sift moves one heap level per
// cycle, set by the parent/child compare in the active cell. A sift walks at
// most 5 levels for 32 entries. In readout the cells shift toward cell 0, one
// kept entry per shift.
// The status item sits in an output register, so the next candidate is taken
// while it still waits. If the receiver stalls, the block holds in its status
// or readout step until the output register frees.
// k_limit is written over the APB port at byte address 0; write only while idle.
// Reset (rst, synchronous) empties the heap and sets k_limit to 1; entry
// storage is not cleared, only the fill count.
module bounded_top_k_max_heap (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [btkh_pkg::DIST_W-1:0]   distance,
  input  logic [31:0]                   tag,
  input  logic                          last_candidate,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    action,
  output logic [btkh_pkg::DIST_W-1:0]   result_distance,
  output logic [31:0]                   result_tag,
  output logic [btkh_pkg::CNT_W-1:0]    kept_count,
  output logic                          heap_full,
  output logic                          run_end
);
  import btkh_pkg::*;

  state_t              state;
  state_t              state_next;
  logic [5:0]          k_limit;
  logic [CNT_W-1:0]    k_eff;
  logic [CNT_W-1:0]    fill;
  logic [IDX_W-1:0]    pos;
  logic [CNT_W-1:0]    rd_cnt;
  logic                last_r;
  action_t             act_r;

  cell_ctrl_t          cctrl;
  logic [DIST_W-1:0]   cd [MAX_K];
  logic [TAG_BITS-1:0] ct [MAX_K];
  cell_flags_t         cf [MAX_K];

  logic                accept;
  logic                do_ins;
  logic                do_rep;
  logic                out_free;
  logic                any_up;
  logic                any_dl;
  logic                any_dr;
  logic                is_full;
  logic [IDX_W:0]      down_pos;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_K_LIMIT) ? 32'(k_limit) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      k_limit <= 6'd1;
    end else if (psel && penable && pwrite && (paddr[2] == REG_K_LIMIT)) begin
      k_limit <= pwdata[5:0];
    end
  end

  always_comb begin
    if (k_limit == 6'd0) begin
      k_eff = CNT_W'(1);
    end else if (k_limit > 6'(MAX_K)) begin
      k_eff = CNT_W'(MAX_K);
    end else begin
      k_eff = CNT_W'(k_limit);
    end
  end

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign do_ins   = (fill < k_eff);
  assign do_rep   = !do_ins && (distance <= cd[0]);
  assign out_free = !out_valid || out_ready;
  assign is_full  = (fill >= k_eff);

  always_comb begin
    any_up = 1'b0;
    any_dl = 1'b0;
    any_dr = 1'b0;
    for (int i = 0; i < MAX_K; i++) begin
      any_up = any_up | cf[i].up_swap;
      any_dl = any_dl | cf[i].dn_swap_l;
      any_dr = any_dr | cf[i].dn_swap_r;
    end
  end

  assign down_pos = {pos, 1'b0} + (any_dr ? (IDX_W+1)'(2) : (IDX_W+1)'(1));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (do_ins) begin
            state_next = ST_UP;
          end else if (do_rep) begin
            state_next = ST_DOWN;
          end else begin
            state_next = ST_STATUS;
          end
        end
      end
      ST_UP: begin
        if (!any_up) state_next = ST_STATUS;
      end
      ST_DOWN: begin
        if (!(any_dl || any_dr)) state_next = ST_STATUS;
      end
      ST_STATUS: begin
        if (out_free) begin
          if (last_r && (fill != '0)) begin
            state_next = ST_READ;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_READ: begin
        if (out_free && (rd_cnt + CNT_W'(1) == fill)) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // cell control
  always_comb begin
    cctrl.op        = OP_HOLD;
    cctrl.pos       = pos;
    cctrl.fill      = fill;
    cctrl.load_dist = distance;
    cctrl.load_tag  = TAG_BITS'(tag);
    case (state)
      ST_IDLE: begin
        if (accept && (do_ins || do_rep)) begin
          cctrl.op  = OP_LOAD;
          cctrl.pos = do_ins ? fill[IDX_W-1:0] : '0;
        end
      end
      ST_UP:   cctrl.op = OP_UP;
      ST_DOWN: cctrl.op = OP_DOWN;
      ST_READ: begin
        if (out_free) cctrl.op = OP_SHIFT;
      end
      default: cctrl.op = OP_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (((state == ST_STATUS) || (state == ST_READ)) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (do_ins) begin
              fill <= fill + CNT_W'(1);
            end
          end
        end
        ST_READ: begin
          if (out_free) begin
            if (rd_cnt + CNT_W'(1) == fill) fill <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload and step registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          pos    <= do_ins ? fill[IDX_W-1:0] : '0;
          last_r <= last_candidate;
          act_r  <= do_ins ? ACT_INSERT : (do_rep ? ACT_REPLACE : ACT_REJECT);
        end
      end
      ST_UP: begin
        if (any_up) pos <= IDX_W'((pos - IDX_W'(1)) >> 1);
      end
      ST_DOWN: begin
        if (any_dl || any_dr) pos <= down_pos[IDX_W-1:0];
      end
      ST_STATUS: begin
        if (out_free) begin
          action          <= act_r;
          result_distance <= (fill != '0) ? cd[0] : '0;
          result_tag      <= 32'd0;
          kept_count      <= fill;
          heap_full       <= is_full;
          run_end         <= !last_r;
          rd_cnt          <= '0;
        end
      end
      ST_READ: begin
        if (out_free) begin
          action          <= ACT_READOUT;
          result_distance <= cd[0];
          result_tag      <= 32'(ct[0]);
          kept_count      <= fill;
          heap_full       <= is_full;
          run_end         <= (rd_cnt + CNT_W'(1) == fill);
          rd_cnt          <= rd_cnt + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // row of heap cells; entry i has parent (i-1)/2 and children 2i+1, 2i+2
  for (genvar i = 0; i < MAX_K; i++) begin : g_cell
    localparam int PI = (i == 0) ? 0 : (i - 1) / 2;
    logic [DIST_W-1:0]   pd, ld, rd, nd;
    logic [TAG_BITS-1:0] pt, lt, rt, nt;
    cell_flags_t         pf, lf, rf;

    if (i == 0) begin : g_par
      assign pd = cd[0];
      assign pt = ct[0];
      assign pf = '0;
    end else begin : g_par
      assign pd = cd[PI];
      assign pt = ct[PI];
      assign pf = cf[PI];
    end

    if (2 * i + 1 < MAX_K) begin : g_left
      assign ld = cd[2*i+1];
      assign lt = ct[2*i+1];
      assign lf = cf[2*i+1];
    end else begin : g_left
      assign ld = '0;
      assign lt = '0;
      assign lf = '0;
    end

    if (2 * i + 2 < MAX_K) begin : g_right
      assign rd = cd[2*i+2];
      assign rt = ct[2*i+2];
      assign rf = cf[2*i+2];
    end else begin : g_right
      assign rd = '0;
      assign rt = '0;
      assign rf = '0;
    end

    if (i + 1 < MAX_K) begin : g_next
      assign nd = cd[i+1];
      assign nt = ct[i+1];
    end else begin : g_next
      assign nd = '0;
      assign nt = '0;
    end

    btkh_cell u_cell (
      .clk         (clk),
      .idx         (IDX_W'(i)),
      .ctrl        (cctrl),
      .par_dist    (pd),
      .par_tag     (pt),
      .par_flags   (pf),
      .left_dist   (ld),
      .left_tag    (lt),
      .left_flags  (lf),
      .right_dist  (rd),
      .right_tag   (rt),
      .right_flags (rf),
      .next_dist   (nd),
      .next_tag    (nt),
      .entry_dist  (cd[i]),
      .tag         (ct[i]),
      .flags       (cf[i])
    );
  end

endmodule

>>> tb/tb_bounded_top_k_max_heap.sv
module tb_bounded_top_k_max_heap;
  timeunit 1ns;
  timeprecision 1ps;

  import btkh_pkg::*;

  localparam int CYCLE_LIMIT = 500_000;
  localparam int RANDOM_ITEMS = 160;
  localparam int CALM_TAIL = 130;   // past this many random items, no idling

  typedef struct {
    action_t            act;
    logic [DIST_W-1:0]  res_dist;
    logic [31:0]        tag;
    logic [CNT_W-1:0]   count;
    logic               full;
    logic               fin;
  } heap_result_t;

  // Tracks the kept set of nearest candidates and the items the block owes us.
  class topk_heap_scoreboard;
    logic [DIST_W-1:0]    dist_heap [MAX_K];
    logic [TAG_BITS-1:0]  tag_heap [MAX_K];
    int                   fill;
    logic [5:0]           k_reg;
    heap_result_t         owed_q [$];
    int                   errors;

    function new();
      fill = 0;
      k_reg = 6'd1;
      errors = 0;
    endfunction

    function int eff_k();
      if (k_reg == 0) return 1;
      if (k_reg > MAX_K) return MAX_K;
      return k_reg;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void swap_at(int a, int b);
      logic [DIST_W-1:0] d;
      logic [TAG_BITS-1:0] t;
      d = dist_heap[a];
      t = tag_heap[a];
      dist_heap[a] = dist_heap[b];
      tag_heap[a] = tag_heap[b];
      dist_heap[b] = d;
      tag_heap[b] = t;
    endfunction

    function void take_candidate(logic [DIST_W-1:0] cand_dist, logic [31:0] tg, logic last);
      int k;
      int p;
      int c;
      action_t act;
      heap_result_t r;
      k = eff_k();
      if (fill < k) begin
        dist_heap[fill] = cand_dist;
        tag_heap[fill] = tg[TAG_BITS-1:0];
        p = fill;
        fill++;
        while (p > 0) begin
          c = (p - 1) / 2;
          if (dist_heap[c] < dist_heap[p]) begin
            swap_at(c, p);
            p = c;
          end else begin
            break;
          end
        end
        act = ACT_INSERT;
      end else if (cand_dist <= dist_heap[0]) begin
        dist_heap[0] = cand_dist;
        tag_heap[0] = tg[TAG_BITS-1:0];
        p = 0;
        while (2 * p + 1 < fill) begin
          c = 2 * p + 1;
          // equal children: left one wins
          if (c + 1 < fill && dist_heap[c] < dist_heap[c + 1]) c++;
          if (dist_heap[p] < dist_heap[c]) begin
            swap_at(p, c);
            p = c;
          end else begin
            break;
          end
        end
        act = ACT_REPLACE;
      end else begin
        act = ACT_REJECT;
      end

      r.act = act;
      r.res_dist = (fill > 0) ? dist_heap[0] : '0;
      r.tag = '0;
      r.count = CNT_W'(fill);
      r.full = (fill >= k);
      r.fin = !last;
      owed_q.push_back(r);

      if (last) begin
        for (int i = 0; i < fill; i++) begin
          r.act = ACT_READOUT;
          r.res_dist = dist_heap[i];
          r.tag = 32'(tag_heap[i]);
          r.fin = (i + 1 == fill);
          owed_q.push_back(r);
        end
        fill = 0;
      end
    endfunction

    function void check_output(logic [1:0] act, logic [DIST_W-1:0] got_dist, logic [31:0] tg,
                               logic [CNT_W-1:0] count, logic full, logic fin);
      heap_result_t e;
      if (owed_q.size() == 0) begin
        $error("unexpected item: action %0d distance %h", act, got_dist);
        errors++;
        return;
      end
      e = owed_q.pop_front();
      if (act !== e.act) begin
        $error("action: expected %0d actual %0d", e.act, act);
        errors++;
      end
      if (got_dist !== e.res_dist) begin
        $error("result_distance: expected %h actual %h", e.res_dist, got_dist);
        errors++;
      end
      if (tg !== e.tag) begin
        $error("result_tag: expected %h actual %h", e.tag, tg);
        errors++;
      end
      if (count !== e.count) begin
        $error("kept_count: expected %0d actual %0d", e.count, count);
        errors++;
      end
      if (full !== e.full) begin
        $error("heap_full: expected %0b actual %0b", e.full, full);
        errors++;
      end
      if (fin !== e.fin) begin
        $error("run_end: expected %0b actual %0b", e.fin, fin);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [2:0]           paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 in_valid;
  logic                 in_ready;
  logic [DIST_W-1:0]    distance;
  logic [31:0]          tag;
  logic                 last_candidate;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           action;
  logic [DIST_W-1:0]    result_distance;
  logic [31:0]          result_tag;
  logic [CNT_W-1:0]     kept_count;
  logic                 heap_full;
  logic                 run_end;

  logic                 jitter_on = 1'b1;
  int                   stall_left = 0;
  int                   cycles = 0;

  topk_heap_scoreboard  heap_sb = new();

  bounded_top_k_max_heap dut (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .distance        (distance),
    .tag             (tag),
    .last_candidate  (last_candidate),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .action          (action),
    .result_distance (result_distance),
    .result_tag      (result_tag),
    .kept_count      (kept_count),
    .heap_full       (heap_full),
    .run_end         (run_end)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver stalls in random bursts while jitter is on
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (jitter_on && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(1, 5) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      heap_sb.check_output(action, result_distance, result_tag, kept_count, heap_full,
                           run_end);
  end

  // leaves in_valid high so back-to-back items need no second assignment
  task automatic send_candidate(input logic [DIST_W-1:0] d, input logic [31:0] t,
                                input logic l);
    int gap;
    gap = (jitter_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    distance <= d;
    tag <= t;
    last_candidate <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    heap_sb.take_candidate(d, t, l);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (heap_sb.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_k_limit(input logic [5:0] k);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_K_LIMIT, 2'b00};
    pwdata <= {26'd0, k};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    heap_sb.k_reg = k;
  endtask

  initial begin
    int rand_items;
    int eff;
    int run_len;
    int dist_mode;
    bit run_jitter;
    logic [5:0] k;
    logic [DIST_W-1:0] d;
    logic l;

    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    distance = '0;
    tag = '0;
    last_candidate = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // k at reset value 1: insert, tie replaces, reject, readout
    send_candidate(32'h0000_0000, 32'hA000_0000, 1'b0);
    send_candidate(32'h0000_0000, 32'hA000_0001, 1'b0);
    send_candidate(32'hFFFF_FFFF, 32'hA000_0002, 1'b0);
    send_candidate(32'h0000_0001, 32'hFFFF_FFFF, 1'b1);

    // zero behaves as one
    set_k_limit(6'd0);
    send_candidate(32'hFFFF_FFFF, 32'hA000_0004, 1'b0);
    send_candidate(32'hFFFF_FFFF, 32'hA000_0005, 1'b1);

    // sift up on fill, sift down on replace; heap left full, no readout
    set_k_limit(6'd4);
    send_candidate(32'd10 << 8, 32'hB000_0000, 1'b0);
    send_candidate(32'd20 << 8, 32'hB000_0001, 1'b0);
    send_candidate(32'd30 << 8, 32'hB000_0002, 1'b0);
    send_candidate(32'd40 << 8, 32'hB000_0003, 1'b0);
    send_candidate(32'd5 << 8, 32'hB000_0004, 1'b0);
    send_candidate(32'd50 << 8, 32'hB000_0005, 1'b0);

    // k dropped under the held count: counts as full, count stays 4
    set_k_limit(6'd2);
    send_candidate(32'd3 << 8, 32'hB000_0006, 1'b0);
    send_candidate(32'd99 << 8, 32'hB000_0007, 1'b1);

    // equal children on sift down: left one moves up
    set_k_limit(6'd3);
    send_candidate(32'd10, 32'hC000_0000, 1'b0);
    send_candidate(32'd7, 32'hC000_0001, 1'b0);
    send_candidate(32'd7, 32'hC000_0002, 1'b0);
    send_candidate(32'd2, 32'hC000_0003, 1'b1);

    // above MAX_K saturates
    set_k_limit(6'd63);
    send_candidate(32'h0000_0000, 32'h0000_0000, 1'b0);
    send_candidate(32'hFFFF_FFFF, 32'h5555_AAAA, 1'b1);

    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 11))
        0: k = 6'd0;
        1: k = 6'd1;
        2: k = 6'(MAX_K);
        3: k = 6'd33;
        4: k = 6'd63;
        5: k = 6'($urandom_range(0, 63));
        default: k = 6'($urandom_range(2, 8));
      endcase
      set_k_limit(k);
      eff = heap_sb.eff_k();
      run_len = $urandom_range(eff / 2 + 1, eff + 6);
      if (run_len > RANDOM_ITEMS - rand_items) run_len = RANDOM_ITEMS - rand_items;
      dist_mode = $urandom_range(0, 2);
      run_jitter = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < run_len; i++) begin
        jitter_on <= run_jitter && (rand_items < CALM_TAIL);
        case (dist_mode)
          0: d = $urandom;
          1: d = $urandom_range(0, 15);          // many ties
          default: d = 32'hFFFF_FFF0 | $urandom_range(0, 15);
        endcase
        if ($urandom_range(0, 7) == 0) d = $urandom;
        l = (i == run_len - 1) ? ($urandom_range(0, 5) != 0) : ($urandom_range(0, 19) == 0);
        send_candidate(d, $urandom, l);
        rand_items++;
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (heap_sb.pending() != 0) begin
      $error("%0d expected items never arrived", heap_sb.pending());
      heap_sb.errors++;
    end
    if (heap_sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
